// ----- src/wtsa_pkg.sv -----
// Shared constants and types of the sliding-window three-sigma anomaly unit.
package wtsa_pkg;

   // Window geometry (must be a power of two)
   localparam int WIN_SIZE = 16;
   localparam int WIN_LOG  = $clog2(WIN_SIZE);

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int K_W      = 4;
   localparam int SPREAD_W = 22;

   // Reset value of the sigma multiple
   localparam logic [K_W-1:0] K_RESET = K_W'(3);

   // Running sum and running sum of squares
   localparam int SUM_W = SAMPLE_W + WIN_LOG;
   localparam int SQ_W  = 2 * SAMPLE_W - 1 + WIN_LOG;

   // Arithmetic widths of the test
   localparam int S2_W   = 2 * SUM_W - 1;
   localparam int NQ_W   = SQ_W + WIN_LOG;
   localparam int SPR_W  = ((NQ_W > S2_W) ? NQ_W : S2_W) + 1;
   localparam int MAG_W  = SPR_W - 1;
   localparam int DEV_W  = SUM_W + 1;
   localparam int DSQ_W  = 2 * DEV_W - 1;
   localparam int K2_W   = 2 * K_W;
   localparam int RHS_W  = K2_W + MAG_W;
   localparam int CMP_W  = (RHS_W > DSQ_W) ? RHS_W : DSQ_W;
   localparam int SAT_W  = (MAG_W > SPREAD_W) ? MAG_W : SPREAD_W;

   localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

   // Stream payload widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Window statistics after one sample update
   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]            sq;
      logic signed [SAMPLE_W-1:0] x;
   } stats_type;

endpackage

// ----- src/wtsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wtsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wtsa_stats.sv -----
// Sample window in RAM with read-modify-write of the running sum and sum of squares.
module wtsa_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wtsa_pkg::SAMPLE_W-1:0] sample,
   output logic                                stats_valid,
   output wtsa_pkg::stats_type                 stats
);
   import wtsa_pkg::*;

   logic [WIN_LOG-1:0]         slot_ff, slot_in;
   logic                       full_ff, full_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic                       vld_ff, vld_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [SAMPLE_W-1:0]        ram_rd;
   logic signed [SAMPLE_W-1:0] old_smp;
   logic signed [2*SAMPLE_W-1:0] x_sq, old_sq;

   // Window storage; entries are read once per item at the oldest slot
   wtsa_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WIN_SIZE)
   ) u_win (
      .clock   (clock),
      .wr_en   (rd_pend_ff),
      .wr_addr (slot_ff),
      .wr_data (x_ff),
      .rd_en   (start),
      .rd_addr (slot_ff),
      .rd_data (ram_rd)
   );

   // Slots not yet written since reset read as zero until the first wrap
   assign old_smp = full_ff ? $signed(ram_rd) : '0;
   assign x_sq    = x_ff * x_ff;
   assign old_sq  = old_smp * old_smp;

   // Update sums in the cycle the old sample returns, then write back
   always_comb begin
      x_in       = start ? sample : x_ff;
      rd_pend_in = start;
      vld_in     = rd_pend_ff;
      slot_in    = slot_ff;
      full_in    = full_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      if (rd_pend_ff) begin
         sum_in  = sum_ff + SUM_W'(x_ff) - SUM_W'(old_smp);
         sq_in   = sq_ff + SQ_W'(x_sq[2*SAMPLE_W-2:0]) - SQ_W'(old_sq[2*SAMPLE_W-2:0]);
         slot_in = slot_ff + WIN_LOG'(1);
         if (slot_ff == WIN_LOG'(WIN_SIZE - 1)) begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         full_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
         vld_ff     <= 1'b0;
         sum_ff     <= '0;
         sq_ff      <= '0;
      end else begin
         slot_ff    <= slot_in;
         full_ff    <= full_in;
         rd_pend_ff <= rd_pend_in;
         vld_ff     <= vld_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
      end
   end

   // Sample register, payload only
   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign stats_valid = vld_ff;
   assign stats.sum   = sum_ff;
   assign stats.sq    = sq_ff;
   assign stats.x     = x_ff;

endmodule

// ----- src/wtsa_eval.sv -----
// Spread, mean and anomaly test pipeline with the result output register.
module wtsa_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         stats_valid,
   input  wtsa_pkg::stats_type          stats,
   input  logic [wtsa_pkg::K_W-1:0]     sigma_k,
   output logic                         done,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [wtsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                         rsp_tuser
);
   import wtsa_pkg::*;

   logic                      a_vld_ff, a_vld_in;
   logic                      b_vld_ff, b_vld_in;
   logic                      out_vld_ff, out_vld_in;
   logic [S2_W-1:0]           s2_ff;
   logic [DSQ_W-1:0]          dsq_ff;
   logic [K2_W-1:0]           k2_ff;
   logic [MAG_W-1:0]          spread_ff, spread_in;
   logic [SAMPLE_W-1:0]       mean_ff;
   logic                      anom_ff, anom_in;
   logic [SAMPLE_W-1:0]       mean_out_ff;
   logic [SPREAD_W-1:0]       spread_out_ff, spread_out_in;
   logic signed [2*SUM_W-1:0] sum_prod;
   logic signed [DEV_W-1:0]   dev;
   logic signed [2*DEV_W-1:0] dev_prod;
   logic [SPR_W-1:0]          nq, diff;
   logic [RHS_W-1:0]          rhs;
   logic [SAT_W-1:0]          spread_ext;
   logic                      load;

   // Stage A: S^2, (N*x - S)^2 and k^2
   assign sum_prod = stats.sum * stats.sum;
   assign dev      = (DEV_W'(stats.x) <<< WIN_LOG) - DEV_W'(stats.sum);
   assign dev_prod = dev * dev;

   always_ff @(posedge clock) begin
      if (stats_valid) begin
         s2_ff  <= sum_prod[S2_W-1:0];
         dsq_ff <= dev_prod[DSQ_W-1:0];
         k2_ff  <= K2_W'(sigma_k) * K2_W'(sigma_k);
      end
   end

   // Stage B: spread N*Q - S^2 clamped at zero, floor mean
   assign nq   = SPR_W'(stats.sq) << WIN_LOG;
   assign diff = nq - SPR_W'(s2_ff);
   assign spread_in = diff[SPR_W-1] ? '0 : diff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (a_vld_ff) begin
         spread_ff <= spread_in;
         mean_ff   <= stats.sum[SUM_W-1:WIN_LOG];
      end
   end

   // Stage C: threshold compare and saturation into the output register
   assign rhs        = RHS_W'(k2_ff) * RHS_W'(spread_ff);
   assign anom_in    = CMP_W'(dsq_ff) > CMP_W'(rhs);
   assign spread_ext = SAT_W'(spread_ff);
   assign spread_out_in = (spread_ext > SAT_W'(SPREAD_MAX)) ? SPREAD_MAX
                                                            : spread_ext[SPREAD_W-1:0];
   assign load = b_vld_ff && (!out_vld_ff || rsp_tready);

   always_comb begin
      a_vld_in   = stats_valid;
      b_vld_in   = a_vld_ff || (b_vld_ff && !load);
      out_vld_in = load || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         anom_ff       <= anom_in;
         mean_out_ff   <= mean_ff;
         spread_out_ff <= spread_out_in;
      end
   end

   assign done       = load;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = anom_ff;
   assign rsp_tdata  = RSP_DATA_W'({spread_out_ff, mean_out_ff});

endmodule

// ----- src/window_three_sigma_anomaly_unit.sv -----
// Top level of the sliding-window three-sigma anomaly unit.
//
// Channels: req_* carries one signed 8-bit RSSI sample per item. rsp_* returns
// one result item per sample: the anomaly flag on rsp_tuser, the floor mean of
// the window and the scaled spread N*Q - S^2 (saturated to 22 bits) on
// rsp_tdata. csr_* writes the 4-bit sigma multiple k, which resets to 3; write
// it only while no item is in flight.
// The sample passes the window RAM read-modify-write, then the multiply, spread
// and compare stages, and then the output register when that register is free.
// One item is in flight at a time and req_tready returns at the edge that loads
// its result, so no new sample is accepted before the last one is through.
// Reset clears the window (unwritten slots read as zero until the first wrap),
// the running sums and the oldest-slot pointer; there is no clearing pass.
// If the receiver stalls, the finished result waits in the output register
// while the next sample is accepted and processed; that sample then holds in
// the last stage until the output register frees.
module window_three_sigma_anomaly_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: rssi_dbm[7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wtsa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: mean_dbm[7:0], spread_scaled[29:8], zero fill[31:30]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wtsa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: anomaly[0]
   output logic                                rsp_tuser,
   // csr_data: sigma_multiple[3:0]
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wtsa_pkg::K_W-1:0]            csr_data
);
   import wtsa_pkg::*;

   logic            busy_ff, busy_in;
   logic [K_W-1:0]  k_ff, k_in;
   logic            accept;
   logic            done;
   logic            stats_valid;
   stats_type       stats;

   // One item in flight: block new samples until the result is loaded
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign busy_in    = accept || (busy_ff && !done);

   // Configuration register
   assign csr_ready = 1'b1;
   assign k_in      = (csr_valid && csr_ready) ? csr_data : k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= K_RESET;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   wtsa_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .sample      ($signed(req_tdata[SAMPLE_W-1:0])),
      .stats_valid (stats_valid),
      .stats       (stats)
   );

   wtsa_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .stats_valid (stats_valid),
      .stats       (stats),
      .sigma_k     (k_ff),
      .done        (done),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- src/wtsa_checker.sv -----
// Port-level checks of the anomaly unit, bound to the top level.
module wtsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wtsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one sample in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted while another is in flight");

   // With a free output register an accepted sample yields a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |-> ##5 rsp_tvalid)
      else $error("result missing after fixed latency");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind window_three_sigma_anomaly_unit wtsa_checker u_wtsa_checker (.*);
